// ===== src/cell_matrix_response_top_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cell matrix response block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CELL_MATRIX_RESPONSE_TOP_ASSERT_SVH
`define CELL_MATRIX_RESPONSE_TOP_ASSERT_SVH

// Condition that must hold at every clock edge out of reset.
`define CMR_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cell_matrix_response: invariant violated");

// Consequent that must hold in the same cycle as the antecedent.
`define CMR_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cell_matrix_response: implication violated");

`endif

// ===== src/cmr_pkg.sv =====
// ----------------------------------------------------------------------------
// Cell matrix response package
// Shared widths, types and register index codes.
// ----------------------------------------------------------------------------
package cmr_pkg;

    // Width of a signed Q1.14 vector component.
    localparam int VEC_W = 16;
    // Width of an unsigned Q0.16 fraction.
    localparam int FRAC_W = 16;
    // Quotient bits produced by the unit-length divider.
    localparam int QUO_W = 16;
    // Configuration port.
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic [FRAC_W-1:0] frac_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_MOTILITY = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_FTYPE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_IDX_SPEED    = 2'd2;

endpackage

// ===== src/cmr_unit_vec.sv =====
// ----------------------------------------------------------------------------
// Pipelined unit-length scaler
// Squares, sums, takes a pipelined integer root and divides each component
// by it, one bit per stage, returning signed Q1.14 components.
// ----------------------------------------------------------------------------
module cmr_unit_vec
    import cmr_pkg::*;
#(
    parameter int CW   = 16,
    parameter int PRE  = 28,
    parameter int POST = 28,
    parameter int SW   = 1
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_vld,
    input  logic signed [CW-1:0] in_c [3],
    input  logic [SW-1:0]        in_side,
    output logic                 out_vld,
    output vec_t                 out_c [3],
    output logic [SW-1:0]        out_side
);

    localparam int SQW = 2 * CW;
    localparam int SSW = SQW + 2 + PRE;
    localparam int RW  = SSW / 2;
    localparam int RMW = RW + 3;
    localparam int NW  = CW + POST + 1;
    localparam int CMW = (NW > RW + QUO_W) ? NW : RW + QUO_W;

    // Magnitude stage.
    logic          a_vld_reg;
    logic [CW-1:0] a_mag_reg [3];
    logic [2:0]    a_neg_reg;
    logic [SW-1:0] a_side_reg;

    // Square stage.
    logic           b_vld_reg;
    logic [SQW-1:0] b_sq_reg [3];
    logic [CW-1:0]  b_mag_reg [3];
    logic [2:0]     b_neg_reg;
    logic [SW-1:0]  b_side_reg;

    // Root stages.
    logic           sq_vld_reg  [RW+1];
    logic [SSW-1:0] sq_rad_reg  [RW+1];
    logic [RMW-1:0] sq_rem_reg  [RW+1];
    logic [RW-1:0]  sq_root_reg [RW+1];
    logic [CW-1:0]  sq_mag_reg  [RW+1][3];
    logic [2:0]     sq_neg_reg  [RW+1];
    logic           sq_zero_reg [RW+1];
    logic [SW-1:0]  sq_side_reg [RW+1];

    // Divide stages.
    logic             dv_vld_reg  [QUO_W+1];
    logic [CMW-1:0]   dv_rem_reg  [QUO_W+1][3];
    logic [QUO_W-1:0] dv_q_reg    [QUO_W+1][3];
    logic [RW-1:0]    dv_n_reg    [QUO_W+1];
    logic [2:0]       dv_neg_reg  [QUO_W+1];
    logic             dv_zero_reg [QUO_W+1];
    logic [SW-1:0]    dv_side_reg [QUO_W+1];

    logic            o_vld_reg;
    vec_t            o_c_reg [3];
    logic [SW-1:0]   o_side_reg;

    logic [SQW+1:0]  ss_sum;
    logic [NW-1:0]   num_init [3];
    vec_t            o_c_next [3];

    always_comb
    begin
        ss_sum = (SQW+2)'(b_sq_reg[0]) + (SQW+2)'(b_sq_reg[1]) + (SQW+2)'(b_sq_reg[2]);
        for (int i = 0; i < 3; i++)
        begin
            num_init[i] = (NW'(sq_mag_reg[RW][i]) << POST) + NW'(sq_root_reg[RW] >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            sq_vld_reg[0]  <= 1'b0;
            dv_vld_reg[0]  <= 1'b0;
            o_vld_reg      <= 1'b0;
        end
        else
        begin
            a_vld_reg      <= in_vld;
            b_vld_reg      <= a_vld_reg;
            sq_vld_reg[0]  <= b_vld_reg;
            dv_vld_reg[0]  <= sq_vld_reg[RW];
            o_vld_reg      <= dv_vld_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag_reg[i] <= in_c[i][CW-1] ? (~$unsigned(in_c[i]) + 1'b1) : $unsigned(in_c[i]);
            a_neg_reg[i] <= in_c[i][CW-1];
            b_sq_reg[i]  <= a_mag_reg[i] * a_mag_reg[i];
            b_mag_reg[i] <= a_mag_reg[i];
            sq_mag_reg[0][i] <= b_mag_reg[i];
            dv_rem_reg[0][i] <= CMW'(num_init[i]);
            dv_q_reg[0][i]   <= '0;
            o_c_reg[i]       <= o_c_next[i];
        end
        a_side_reg      <= in_side;
        b_neg_reg       <= a_neg_reg;
        b_side_reg      <= a_side_reg;
        sq_rad_reg[0]   <= SSW'(ss_sum) << PRE;
        sq_rem_reg[0]   <= '0;
        sq_root_reg[0]  <= '0;
        sq_neg_reg[0]   <= b_neg_reg;
        sq_zero_reg[0]  <= (ss_sum == '0);
        sq_side_reg[0]  <= b_side_reg;
        dv_n_reg[0]     <= sq_root_reg[RW];
        dv_neg_reg[0]   <= sq_neg_reg[RW];
        dv_zero_reg[0]  <= sq_zero_reg[RW];
        dv_side_reg[0]  <= sq_side_reg[RW];
        o_side_reg      <= dv_side_reg[QUO_W];
    end

    // One root bit per stage, two radicand bits brought down each time.
    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        logic [RMW-1:0] rem_t;
        logic [RMW-1:0] trial;
        logic           ge;

        always_comb
        begin
            rem_t = {sq_rem_reg[k][RMW-3:0], sq_rad_reg[k][SSW-1 -: 2]};
            trial = {{(RMW-RW-2){1'b0}}, sq_root_reg[k], 2'b01};
            ge    = (rem_t >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[k+1] <= 1'b0;
            end
            else
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            sq_rad_reg[k+1]  <= sq_rad_reg[k] << 2;
            sq_rem_reg[k+1]  <= ge ? (rem_t - trial) : rem_t;
            sq_root_reg[k+1] <= {sq_root_reg[k][RW-2:0], ge};
            for (int i = 0; i < 3; i++)
            begin
                sq_mag_reg[k+1][i] <= sq_mag_reg[k][i];
            end
            sq_neg_reg[k+1]  <= sq_neg_reg[k];
            sq_zero_reg[k+1] <= sq_zero_reg[k];
            sq_side_reg[k+1] <= sq_side_reg[k];
        end
    end

    // Restoring division, most significant quotient bit first.
    for (genvar s = 0; s < QUO_W; s++)
    begin : g_div
        localparam int SH = QUO_W - 1 - s;
        logic [CMW-1:0] dsh;
        logic [2:0]     ge;

        always_comb
        begin
            dsh = CMW'(dv_n_reg[s]) << SH;
            for (int i = 0; i < 3; i++)
            begin
                ge[i] = (dv_rem_reg[s][i] >= dsh);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[s+1] <= 1'b0;
            end
            else
            begin
                dv_vld_reg[s+1] <= dv_vld_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_rem_reg[s+1][i] <= ge[i] ? (dv_rem_reg[s][i] - dsh) : dv_rem_reg[s][i];
                dv_q_reg[s+1][i]   <= {dv_q_reg[s][i][QUO_W-2:0], ge[i]};
            end
            dv_n_reg[s+1]    <= dv_n_reg[s];
            dv_neg_reg[s+1]  <= dv_neg_reg[s];
            dv_zero_reg[s+1] <= dv_zero_reg[s];
            dv_side_reg[s+1] <= dv_side_reg[s];
        end
    end

    // Sign, clamp, and pass a zero-length vector through as zero.
    always_comb
    begin
        logic [QUO_W-1:0] qc;
        for (int i = 0; i < 3; i++)
        begin
            qc = (dv_q_reg[QUO_W][i] > QUO_W'(32768)) ? QUO_W'(32768) : dv_q_reg[QUO_W][i];
            if (dv_zero_reg[QUO_W])
            begin
                o_c_next[i] = '0;
            end
            else if (dv_neg_reg[QUO_W][i])
            begin
                o_c_next[i] = VEC_W'(~qc + 1'b1);
            end
            else
            begin
                o_c_next[i] = (qc > QUO_W'(32767)) ? VEC_W'(32767) : VEC_W'(qc);
            end
        end
    end

    assign out_vld  = o_vld_reg;
    assign out_c    = o_c_reg;
    assign out_side = o_side_reg;

endmodule

// ===== src/cell_matrix_response_top.sv =====
// Throughput: one request per cycle; busy stays low, as every step is its own stage.
// A request passes through two bit-serial root pipelines (31 and 33 stages) and two
// 16-stage dividers, in series with five speed stages and four blend stages.
// Reset: asynchronous, active low; clears all valid bits and loads the
// configuration defaults. The receiver cannot stall, so no stage ever waits.
// ----------------------------------------------------------------------------
// Cell matrix response top level
// Per cell, derives migration speed and the new bias direction from the
// density, anisotropy and fibre orientation of its voxel and its current heading.
// ----------------------------------------------------------------------------
`include "cell_matrix_response_top_assert.svh"

module cell_matrix_response_top
    import cmr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [3:0]            cell_kind,
    input  logic                  motile_flag,
    input  frac_t                 matrix_density,
    input  frac_t                 matrix_anisotropy,
    input  vec_t                  fibre_x,
    input  vec_t                  fibre_y,
    input  vec_t                  fibre_z,
    input  vec_t                  heading_x,
    input  vec_t                  heading_y,
    input  vec_t                  heading_z,
    output logic                  done,
    output logic                  cell_skipped,
    output logic                  speed_written,
    output frac_t                 new_speed,
    output frac_t                 new_bias,
    output vec_t                  out_heading_x,
    output vec_t                  out_heading_y,
    output vec_t                  out_heading_z,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Fields that ride along the speed stages.
    typedef struct packed {
        logic  skip;
        logic  motile;
        frac_t aniso;
        vec_t  fx;
        vec_t  fy;
        vec_t  fz;
        vec_t  hx;
        vec_t  hy;
        vec_t  hz;
    } front_t;

    localparam int FRONT_N = 5;
    localparam int SIDE_D_W = 2 + FRAC_W;
    localparam int SIDE_B_W = 2 + 2 * FRAC_W;

    // Configuration registers.
    logic        motility_on_reg;
    logic [3:0]  ftype_reg;
    frac_t       top_speed_reg;

    logic        accept;

    // Speed stages: the cell fields travel alongside.
    logic                vld_reg [FRONT_N];
    front_t              fr_reg  [FRONT_N];
    logic signed [16:0]  e_reg;
    logic [30:0]         esq_reg;
    logic [32:0]         factor_reg;
    logic [48:0]         prod_reg;
    frac_t               speed_reg;
    logic [48:0]         prod_round;
    frac_t               speed_next;

    // Unit scaling of heading and fibre.
    logic signed [VEC_W-1:0] hd_in [3];
    logic signed [VEC_W-1:0] fb_in [3];
    vec_t                    du [3];
    vec_t                    fu [3];
    logic                    d_vld;
    logic                    f_vld;
    logic [SIDE_D_W-1:0]     side_d;
    frac_t                   side_f;

    // Blend stages.
    logic                p1_vld_reg;
    vec_t                p1_du_reg [3];
    vec_t                p1_fu_reg [3];
    logic signed [31:0]  p1_dp_reg [3];
    logic [SIDE_B_W-1:0] p1_side_reg;
    logic                p2_vld_reg;
    vec_t                p2_du_reg [3];
    logic signed [16:0]  p2_fu_reg [3];
    logic [SIDE_B_W-1:0] p2_side_reg;
    logic                p3_vld_reg;
    logic signed [34:0]  p3_pa_reg [3];
    logic signed [34:0]  p3_pb_reg [3];
    logic [SIDE_B_W-1:0] p3_side_reg;
    logic                p4_vld_reg;
    logic signed [31:0]  p4_b_reg [3];
    logic [SIDE_B_W-1:0] p4_side_reg;
    logic signed [33:0]  dot;
    logic signed [16:0]  one_minus_a;

    // Blend scaling and result.
    vec_t                hb [3];
    logic                b_vld;
    logic [SIDE_B_W-1:0] side_b;

    logic  done_reg;
    logic  skipped_reg;
    logic  speed_written_reg;
    frac_t new_speed_reg;
    frac_t new_bias_reg;
    vec_t  head_x_reg;
    vec_t  head_y_reg;
    vec_t  head_z_reg;

    // Result conditions watched by the assertions.
    logic  fields_clear;
    logic  heading_in_range;

    // Every stage moves on every cycle, so a request is always taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Configuration writes; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motility_on_reg <= 1'b0;
            ftype_reg       <= 4'd2;
            top_speed_reg   <= 16'd256;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_IDX_MOTILITY: motility_on_reg <= cfg_wdata[0];
                CFG_IDX_FTYPE:    ftype_reg       <= cfg_wdata[3:0];
                CFG_IDX_SPEED:    top_speed_reg   <= cfg_wdata;
                default:          ;
            endcase
        end
    end

    // Valid bits for every stage in the top level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < FRONT_N; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int s = 1; s < FRONT_N; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            p1_vld_reg <= d_vld;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            done_reg   <= b_vld;
        end
    end

    // The speed factor 1 - 4(d-0.5)^2 is built as 2^32 - 4e^2 in Q0.32,
    // then scaled by the top speed and rounded back to Q8.8.
    always_comb
    begin
        prod_round = prod_reg + 49'(64'h8000_0000);
        if (!fr_reg[3].motile)
        begin
            speed_next = '0;
        end
        else if (prod_round[48:32] > 17'd65535)
        begin
            speed_next = 16'hFFFF;
        end
        else
        begin
            speed_next = prod_round[47:32];
        end
    end

    always_ff @(posedge clk)
    begin
        fr_reg[0].skip   <= !motility_on_reg && (cell_kind == ftype_reg);
        fr_reg[0].motile <= motile_flag;
        fr_reg[0].aniso  <= matrix_anisotropy;
        fr_reg[0].fx     <= fibre_x;
        fr_reg[0].fy     <= fibre_y;
        fr_reg[0].fz     <= fibre_z;
        fr_reg[0].hx     <= heading_x;
        fr_reg[0].hy     <= heading_y;
        fr_reg[0].hz     <= heading_z;
        for (int s = 1; s < FRONT_N; s++)
        begin
            fr_reg[s] <= fr_reg[s-1];
        end
        e_reg      <= $signed({1'b0, matrix_density}) - 17'sd32768;
        esq_reg    <= 31'($unsigned(34'(e_reg) * 34'(e_reg)));
        factor_reg <= 33'(64'h1_0000_0000) - {esq_reg, 2'b00};
        prod_reg   <= factor_reg * top_speed_reg;
        speed_reg  <= speed_next;
    end

    assign hd_in[0] = fr_reg[FRONT_N-1].hx;
    assign hd_in[1] = fr_reg[FRONT_N-1].hy;
    assign hd_in[2] = fr_reg[FRONT_N-1].hz;
    assign fb_in[0] = fr_reg[FRONT_N-1].fx;
    assign fb_in[1] = fr_reg[FRONT_N-1].fy;
    assign fb_in[2] = fr_reg[FRONT_N-1].fz;

    // The heading unit carries skip, motile and speed; the fibre unit the
    // anisotropy. Both have the same depth and stay in step.
    cmr_unit_vec #(
        .CW   (VEC_W),
        .PRE  (28),
        .POST (28),
        .SW   (SIDE_D_W)
    ) u_unit_heading (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld_reg[FRONT_N-1]),
        .in_c     (hd_in),
        .in_side  ({fr_reg[FRONT_N-1].skip, fr_reg[FRONT_N-1].motile, speed_reg}),
        .out_vld  (d_vld),
        .out_c    (du),
        .out_side (side_d)
    );

    cmr_unit_vec #(
        .CW   (VEC_W),
        .PRE  (28),
        .POST (28),
        .SW   (FRAC_W)
    ) u_unit_fibre (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (vld_reg[FRONT_N-1]),
        .in_c     (fb_in),
        .in_side  (fr_reg[FRONT_N-1].aniso),
        .out_vld  (f_vld),
        .out_c    (fu),
        .out_side (side_f)
    );

    // The fibre is turned round when it points against the heading, then the
    // two are mixed as a*fibre + (1-a)*heading with a in Q0.16.
    always_comb
    begin
        dot = 34'(p1_dp_reg[0]) + 34'(p1_dp_reg[1]) + 34'(p1_dp_reg[2]);
        one_minus_a = $signed(17'(17'h1_0000 - {1'b0, p2_side_reg[FRAC_W-1:0]}));
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            p1_du_reg[i] <= du[i];
            p1_fu_reg[i] <= fu[i];
            p1_dp_reg[i] <= du[i] * fu[i];
            p2_du_reg[i] <= p1_du_reg[i];
            p2_fu_reg[i] <= dot[33] ? -17'(p1_fu_reg[i]) : 17'(p1_fu_reg[i]);
            p3_pa_reg[i] <= 35'($signed({1'b0, p2_side_reg[FRAC_W-1:0]}) * p2_fu_reg[i]);
            p3_pb_reg[i] <= 35'($signed({1'b0, one_minus_a}) * p2_du_reg[i]);
            p4_b_reg[i]  <= 32'(p3_pa_reg[i] + p3_pb_reg[i]);
        end
        p1_side_reg <= {side_d, side_f};
        p2_side_reg <= p1_side_reg;
        p3_side_reg <= p2_side_reg;
        p4_side_reg <= p3_side_reg;
    end

    cmr_unit_vec #(
        .CW   (32),
        .PRE  (0),
        .POST (14),
        .SW   (SIDE_B_W)
    ) u_unit_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_vld   (p4_vld_reg),
        .in_c     (p4_b_reg),
        .in_side  (p4_side_reg),
        .out_vld  (b_vld),
        .out_c    (hb),
        .out_side (side_b)
    );

    // A skipped follower shows only its skip flag; everything else is zero.
    always_ff @(posedge clk)
    begin
        skipped_reg <= side_b[SIDE_B_W-1];
        if (side_b[SIDE_B_W-1])
        begin
            speed_written_reg <= 1'b0;
            new_speed_reg     <= '0;
            new_bias_reg      <= '0;
            head_x_reg        <= '0;
            head_y_reg        <= '0;
            head_z_reg        <= '0;
        end
        else
        begin
            speed_written_reg <= side_b[SIDE_B_W-2];
            new_speed_reg     <= side_b[2*FRAC_W-1:FRAC_W];
            new_bias_reg      <= side_b[FRAC_W-1:0];
            head_x_reg        <= hb[0];
            head_y_reg        <= hb[1];
            head_z_reg        <= hb[2];
        end
    end

    assign done          = done_reg;
    assign cell_skipped  = skipped_reg;
    assign speed_written = speed_written_reg;
    assign new_speed     = new_speed_reg;
    assign new_bias      = new_bias_reg;
    assign out_heading_x = head_x_reg;
    assign out_heading_y = head_y_reg;
    assign out_heading_z = head_z_reg;

    assign fields_clear = !speed_written && (new_speed == 16'd0) && (new_bias == 16'd0)
                          && (out_heading_x == 16'sd0) && (out_heading_y == 16'sd0)
                          && (out_heading_z == 16'sd0);
    assign heading_in_range = (out_heading_x <= 16'sd16384) && (out_heading_x >= -16'sd16384)
                              && (out_heading_y <= 16'sd16384)
                              && (out_heading_y >= -16'sd16384)
                              && (out_heading_z <= 16'sd16384)
                              && (out_heading_z >= -16'sd16384);

    // The two input scalers must deliver the same cell in the same cycle.
    `CMR_ASSERT_ALWAYS(a_units_in_step, d_vld == f_vld)
    // A skipped follower must leave every other field at zero.
    `CMR_ASSERT_IMPLIES(a_skip_clears, done && cell_skipped, fields_clear)
    // A still cell gets no speed.
    `CMR_ASSERT_IMPLIES(a_still_no_speed, done && !speed_written, new_speed == 16'd0)
    // Each component of a unit heading lies within plus or minus one.
    `CMR_ASSERT_IMPLIES(a_heading_unit, done, heading_in_range)

endmodule
